@@ sv/cbe_pkg.sv @@
// ----------------------------------------------------------------------------
// cbe_pkg
// Shared types, constants and the alphabet mapping of the base62 bit encoder.
// ----------------------------------------------------------------------------
package cbe_pkg;

    localparam int unsigned RES_W    = 13;  // bit reservoir width
    localparam int unsigned HELD_W   = 4;   // bit count width
    localparam int unsigned CHUNK_W  = 6;   // bits in one chunk
    localparam int unsigned CHAR_W   = 7;   // ASCII code width
    localparam int unsigned MAX_SYMS = 3;   // most characters from one byte

    localparam logic [5:0] COMPACT_PATTERN = 6'h1E;
    localparam logic [5:0] LOW5_MASK       = 6'h1F;
    localparam logic [5:0] TOP_BIT_VALUE   = 6'h01;

    // One output character with its end-of-text flag
    typedef struct packed {
        logic [CHAR_W-1:0] ch;
        logic              eot;
    } t_sym;

    // Characters produced by one byte, oldest in slot 0
    typedef struct packed {
        t_sym [MAX_SYMS-1:0] sym;
        logic [1:0]          cnt;
    } t_sym_set;

    // Bits 1 to 4 of a chunk all set
    function automatic logic is_compact(input logic [5:0] v);
        return (v & COMPACT_PATTERN) == COMPACT_PATTERN;
    endfunction

    // Map a 6-bit value to A-Z, a-z, 0-9; codes 62 and 63 give zero
    function automatic logic [CHAR_W-1:0] sym_char(input logic [5:0] v);
        logic [CHAR_W-1:0] c;
        priority if (v < 6'd26) begin
            c = 7'h41 + 7'(v);
        end else if (v < 6'd52) begin
            c = 7'h61 + 7'(v - 6'd26);
        end else if (v < 6'd62) begin
            c = 7'h30 + 7'(v - 6'd52);
        end else begin
            c = '0;
        end
        return c;
    endfunction

endpackage

@@ sv/compact_base62_bit_encoder.sv @@
// ----------------------------------------------------------------------------
// compact_base62_bit_encoder
// Packs string bytes, fed last byte first, into base62 characters.
//
// Input channel: i_data_byte and i_first_of_string with i_in_valid and
// o_in_ready; an input word is taken when both are high. The byte marked
// first_of_string closes the string and drains the reservoir.
// Output channel: o_symbol_char and o_end_of_text with o_out_valid and
// i_out_ready; o_end_of_text marks the string's last character.
// Flow: a taken byte passes through the input register into the result
// register. Each byte yields one to three characters (one or two for most
// bytes, up to three on the byte that closes a string), held in a
// three-entry result register and sent one per cycle while i_out_ready is
// high. The input register takes a new byte while the last character of the
// previous one is sent.
// Reset: empties the input register, the result register and the bit
// reservoir. When the receiver stalls, characters hold in the result
// register, then one more byte waits in the input register before
// o_in_ready drops.
// ----------------------------------------------------------------------------
module compact_base62_bit_encoder
    import cbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [7:0]        i_data_byte,
    input  logic              i_first_of_string,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_symbol_char,
    output logic              o_end_of_text
);

    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_in_first;
    logic       w_can_load;
    logic       w_load;
    t_sym_set   w_set;

    // Move the held byte on when the result register frees up
    assign w_load     = r_in_valid && w_can_load;
    assign o_in_ready = !r_in_valid || w_load;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
        if (i_in_valid && o_in_ready) begin
            r_in_byte  <= i_data_byte;
            r_in_first <= i_first_of_string;
        end
    end

    cbe_chunker u_chunker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_data_byte       (r_in_byte),
        .i_first_of_string (r_in_first),
        .i_load            (w_load),
        .o_set             (w_set)
    );

    cbe_out_queue u_out_queue (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_load        (w_load),
        .i_set         (w_set),
        .o_can_load    (w_can_load),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_symbol_char (o_symbol_char),
        .o_end_of_text (o_end_of_text)
    );

endmodule

@@ sv/cbe_chunker.sv @@
// ----------------------------------------------------------------------------
// cbe_chunker
// Holds the bit reservoir and splits one byte plus waiting bits into up to
// three characters in a single pass; state advances when the set is loaded.
// ----------------------------------------------------------------------------
module cbe_chunker
    import cbe_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_of_string,
    input  logic       i_load,
    output t_sym_set   o_set
);

    logic [RES_W-1:0]  r_res, n_res;
    logic [HELD_W-1:0] r_held, n_held;

    logic [2:0]        w_h;
    logic [RES_W-1:0]  w_res, w_res2, w_res3;
    logic [HELD_W-1:0] w_held, w_held2, w_held3;
    logic [HELD_W-1:0] w_c1, w_c2;
    logic [5:0]        w_v1, w_v2, w_e1, w_e2, w_vf;
    logic              w_take2, w_split;
    t_sym              w_s1, w_s2;

    // Merge the byte above the waiting bits
    always_comb begin
        w_h    = (r_held > 4'd5) ? 3'd5 : r_held[2:0];
        w_res  = (r_res & ((13'd1 << w_h) - 13'd1)) | (13'(i_data_byte) << w_h);
        w_held = 4'(w_h) + 4'd8;
    end

    // First chunk is always taken, second one when enough bits remain
    always_comb begin
        w_v1    = w_res[5:0];
        w_c1    = is_compact(w_v1) ? 4'd5 : 4'(CHUNK_W);
        w_e1    = is_compact(w_v1) ? (w_v1 & LOW5_MASK) : w_v1;
        w_res2  = w_res >> w_c1;
        w_held2 = w_held - w_c1;

        w_v2    = w_res2[5:0];
        w_c2    = is_compact(w_v2) ? 4'd5 : 4'(CHUNK_W);
        w_e2    = is_compact(w_v2) ? (w_v2 & LOW5_MASK) : w_v2;
        w_take2 = i_first_of_string ? (w_held2 > 4'(CHUNK_W)) : (w_held2 >= 4'(CHUNK_W));
        w_res3  = w_take2 ? (w_res2 >> w_c2) : w_res2;
        w_held3 = w_take2 ? (w_held2 - w_c2) : w_held2;

        // Final chunk on the string's first byte
        w_vf    = w_res3[5:0] & 6'((13'd1 << w_held3) - 13'd1);
        w_split = (w_held3 == 4'(CHUNK_W)) && (w_vf[5:1] == 5'h1F);
    end

    // Assemble the character set
    always_comb begin
        w_s1.ch  = sym_char(w_e1);
        w_s1.eot = 1'b0;
        w_s2.ch  = sym_char(w_e2);
        w_s2.eot = 1'b0;

        o_set        = '0;
        o_set.sym[0] = w_s1;
        if (!i_first_of_string) begin
            o_set.sym[1] = w_s2;
            o_set.cnt    = w_take2 ? 2'd2 : 2'd1;
        end else if (w_take2) begin
            o_set.sym[1]     = w_s2;
            o_set.sym[2].ch  = sym_char(w_vf);
            o_set.sym[2].eot = 1'b1;
            o_set.cnt        = 2'd3;
        end else if (w_split) begin
            o_set.sym[1].ch  = sym_char(w_vf & LOW5_MASK);
            o_set.sym[1].eot = 1'b0;
            o_set.sym[2].ch  = sym_char(TOP_BIT_VALUE);
            o_set.sym[2].eot = 1'b1;
            o_set.cnt        = 2'd3;
        end else begin
            o_set.sym[1].ch  = sym_char(w_vf);
            o_set.sym[1].eot = 1'b1;
            o_set.cnt        = 2'd2;
        end
    end

    // Advance the reservoir; drain it at the end of a string
    always_comb begin
        n_res  = r_res;
        n_held = r_held;
        if (i_load) begin
            n_res  = i_first_of_string ? '0 : w_res3;
            n_held = i_first_of_string ? '0 : w_held3;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res  <= '0;
            r_held <= '0;
        end else begin
            r_res  <= n_res;
            r_held <= n_held;
        end
    end

endmodule

@@ sv/cbe_out_queue.sv @@
// ----------------------------------------------------------------------------
// cbe_out_queue
// Result register for up to three characters, sent one word per cycle while i_out_ready is high.
// ----------------------------------------------------------------------------
module cbe_out_queue
    import cbe_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  t_sym_set          i_set,
    output logic              o_can_load,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CHAR_W-1:0] o_symbol_char,
    output logic              o_end_of_text
);

    t_sym [MAX_SYMS-1:0] r_sym, n_sym;
    logic [1:0]          r_cnt, n_cnt;
    logic                w_pop;

    // Take a new set when empty or when the last word leaves now
    assign w_pop       = o_out_valid && i_out_ready;
    assign o_can_load  = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && i_out_ready);
    assign o_out_valid = (r_cnt != 2'd0);
    assign o_symbol_char = r_sym[0].ch;
    assign o_end_of_text = r_sym[0].eot;

    // Load, or shift down on each sent word
    always_comb begin
        n_sym = r_sym;
        n_cnt = r_cnt;
        if (i_load) begin
            n_sym = i_set.sym;
            n_cnt = i_set.cnt;
        end else if (w_pop) begin
            n_sym[0] = r_sym[1];
            n_sym[1] = r_sym[2];
            n_cnt    = r_cnt - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_sym <= n_sym;
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the compact base62 bit encoder. Strings are fed
// last byte first through the input handshake. A bit-level model of the
// reservoir predicts every character and its end-of-text flag. The output
// handshake is compared word by word against the oldest predicted character.
// Both sides idle at random, apart from one stretch that runs at full rate.
// ----------------------------------------------------------------------------
module tb_top;
    import cbe_pkg::*;

    localparam int unsigned MAX_SHOWN  = 10;
    localparam int unsigned IDLE_PCT   = 26;
    localparam int unsigned DRAIN_WAIT = 12;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [7:0]        i_data_byte;
    logic              i_first_of_string;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [CHAR_W-1:0] o_symbol_char;
    logic              o_end_of_text;

    // Predicted reservoir contents and bit count
    logic [RES_W-1:0]  pend_bits;
    logic [HELD_W-1:0] pend_cnt;

    // Characters predicted but not yet seen on the output
    t_sym char_q[$];

    int unsigned n_mismatch;
    int unsigned n_chars;
    int unsigned n_bytes;
    int unsigned n_strings;
    int unsigned n_splits;
    bit          stall_en;

    compact_base62_bit_encoder DUT (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_data_byte       (i_data_byte),
        .i_first_of_string (i_first_of_string),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_symbol_char     (o_symbol_char),
        .o_end_of_text     (o_end_of_text)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    // Hard stop in case the handshake hangs
    initial begin
        #200000;
        $display("CHECK FAILED");
        $finish;
    end

    // ASCII of a 6-bit value; the two unused codes give zero
    function automatic logic [CHAR_W-1:0] char_of(input logic [5:0] v);
        string alpha;
        alpha = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789";
        if (v < 6'd62) begin
            return CHAR_W'(alpha[v]);
        end
        return '0;
    endfunction

    function automatic void push_char(input logic [5:0] v, input logic eot);
        t_sym s;
        s.ch  = char_of(v);
        s.eot = eot;
        char_q.push_back(s);
    endfunction

    // Take one chunk off the reservoir; compact chunks consume only 5 bits
    function automatic logic [5:0] pull_chunk();
        logic [5:0]  v;
        int unsigned used;
        v    = pend_bits[5:0];
        used = CHUNK_W;
        if ((v & COMPACT_PATTERN) == COMPACT_PATTERN) begin
            v    = v & LOW5_MASK;
            used = CHUNK_W - 1;
        end
        pend_bits = pend_bits >> used;
        pend_cnt  = pend_cnt - HELD_W'(used);
        return v;
    endfunction

    // Advance the reservoir by one byte and queue the characters it yields
    task automatic predict_byte(input logic [7:0] b, input logic f);
        logic [5:0]  v;
        int unsigned n;
        n = 0;
        if (pend_cnt > 4'd5) begin
            pend_cnt = 4'd5;
        end
        pend_bits = pend_bits & ((RES_W'(1) << pend_cnt) - RES_W'(1));
        pend_bits = pend_bits | (RES_W'(b) << pend_cnt);
        pend_cnt  = pend_cnt + 4'd8;
        if (!f) begin
            while (pend_cnt >= CHUNK_W && n < MAX_SYMS) begin
                push_char(pull_chunk(), 1'b0);
                n++;
            end
        end else begin
            // Drain: full chunks first, then the final chunk whole
            while (pend_cnt > CHUNK_W && n < 2) begin
                push_char(pull_chunk(), 1'b0);
                n++;
            end
            v = 6'(pend_bits & ((RES_W'(1) << pend_cnt) - RES_W'(1)));
            if (pend_cnt == CHUNK_W && (v & COMPACT_PATTERN) == COMPACT_PATTERN
                    && v > LOW5_MASK) begin
                // Split ending: low 5 bits, then the top bit on its own
                push_char(v & LOW5_MASK, 1'b0);
                push_char((v >> 5) & TOP_BIT_VALUE, 1'b1);
                n_splits++;
            end else begin
                push_char(v, 1'b1);
            end
            pend_bits = '0;
            pend_cnt  = '0;
            n_strings++;
        end
    endtask

    // Present one word and hold it until taken; maybe idle afterwards
    task automatic send_byte(input logic [7:0] b, input logic f);
        i_in_valid        <= 1'b1;
        i_data_byte       <= b;
        i_first_of_string <= f;
        do @(posedge i_clk); while (!o_in_ready);
        predict_byte(b, f);
        n_bytes++;
        if (stall_en && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid        <= 1'b0;
            i_data_byte       <= 8'($urandom);
            i_first_of_string <= 1'($urandom);
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
    endtask

    // Feed a string in transfer order; the last word closes it
    task automatic send_string(input logic [7:0] s[$]);
        foreach (s[k]) begin
            send_byte(s[k], k == s.size() - 1);
        end
    endtask

    // Receiver side: stall at random while enabled
    always @(posedge i_clk) begin
        i_out_ready <= !stall_en || ($urandom_range(99) >= IDLE_PCT);
    end

    // Compare each accepted character with the oldest prediction
    always @(posedge i_clk) begin : char_check
        t_sym want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            n_chars++;
            if (char_q.size() == 0) begin
                n_mismatch++;
                if (n_mismatch <= MAX_SHOWN) begin
                    $display("%0t: unexpected word ch=%h eot=%b", $realtime,
                             o_symbol_char, o_end_of_text);
                end
            end else begin
                want = char_q.pop_front();
                if (o_symbol_char !== want.ch || o_end_of_text !== want.eot) begin
                    n_mismatch++;
                    if (n_mismatch <= MAX_SHOWN) begin
                        $display("%0t: word mismatch ch exp=%h got=%h eot exp=%b got=%b",
                                 $realtime, want.ch, o_symbol_char, want.eot,
                                 o_end_of_text);
                    end
                end
            end
        end
    end

    // One-byte strings at the corners of the byte range
    task automatic test_single_bytes();
        logic [7:0] vals[$];
        vals = '{8'h00, 8'hFF, 8'h55, 8'hAA, 8'h1E, 8'h3F, 8'h80};
        foreach (vals[k]) begin
            send_string('{vals[k]});
        end
    endtask

    // Compact chunks, split endings and short compact endings
    task automatic test_compact_endings();
        send_string('{8'hFE, 8'hFF});
        send_string('{8'hFE, 8'hFB});
        send_string('{8'hC0, 8'hF7});
        send_string('{8'hFF, 8'hFF, 8'hFF, 8'h00});
    endtask

    // Random strings, biased toward compact bit patterns
    task automatic test_random_strings(input int unsigned n_words, input bit idle);
        logic [7:0]  s[$];
        int unsigned sent;
        int unsigned len;
        sent     = 0;
        stall_en = idle;
        while (sent < n_words) begin
            s.delete();
            len = $urandom_range(1, 5);
            repeat (len) begin
                s.push_back(8'($urandom));
                if ($urandom_range(2) == 0) begin
                    s[s.size() - 1] |= 8'h1E << $urandom_range(0, 2);
                end
            end
            send_string(s);
            sent += len;
        end
    endtask

    initial begin
        n_mismatch         = 0;
        n_chars            = 0;
        n_bytes            = 0;
        n_strings          = 0;
        n_splits           = 0;
        stall_en           = 1'b1;
        pend_bits          = '0;
        pend_cnt           = '0;
        i_rst_n           <= 1'b0;
        i_in_valid        <= 1'b0;
        i_data_byte       <= '0;
        i_first_of_string <= 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_single_bytes();
        test_compact_endings();
        test_random_strings(45, 1'b1);
        test_random_strings(25, 1'b0);
        test_random_strings(20, 1'b1);

        // Drop valid and wait for the last characters
        i_in_valid <= 1'b0;
        while (char_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d bytes in %0d strings, checked %0d characters",
                 n_bytes, n_strings, n_chars);
        $display("Split endings seen: %0d, mismatches: %0d", n_splits, n_mismatch);
        if (n_mismatch == 0 && char_q.size() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
